// ----- rtl/lpcf_pkg.sv -----
// Shared types, constants and helpers of the loop point crossfader.
package lpcf_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int WEIGHT_W     = 16;
  localparam int WT_W         = WEIGHT_W + 1;
  localparam int FRAME_W      = 16;
  localparam int CHAN_W       = 3;
  localparam int CHCNT_W      = 4;
  localparam int MAX_CHANNELS = 8;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int Q_W          = 31;
  localparam int NUM_W        = 47;
  localparam int ROOT_IN_W    = 61;
  localparam int PROD_W       = 62;
  localparam int ACC_W        = 44;

  localparam logic [CFG_ADDR_W-1:0] REG_FADE_LENGTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_TYPE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [Q_W-1:0] SIN_C1  = 31'd1686629713;
  localparam logic [Q_W-1:0] SIN_C3  = 31'd693598668;
  localparam logic [Q_W-1:0] SIN_C5  = 31'd85569306;
  localparam logic [Q_W-1:0] SIN_C7  = 31'd5026995;
  localparam logic [Q_W-1:0] SIN_C9  = 31'd172272;
  localparam logic [Q_W-1:0] SIN_C11 = 31'd3864;
  localparam logic [2:0]     HORNER_LAST = 3'd4;

  typedef enum logic [1:0] {
    CURVE_LINEAR, CURVE_SCURVE, CURVE_EQPOW, CURVE_SINE
  } curve_e;

  typedef enum logic [1:0] { DIV_X, DIV_LIN, DIV_EP } div_sel_e;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_XX, MUL_YY, MUL_RU, MUL_RX, MUL_SS, MUL_A0, MUL_A1, MUL_A2, MUL_A3
  } mul_sel_e;

  typedef enum logic [1:0] { W_LIN, W_SINE, W_SCURVE, W_EP } wsrc_e;

  typedef enum logic [1:0] { ACC_HOLD, ACC_CLR, ACC_ADD } acc_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_XDIV, S_XWAIT, S_LDIV, S_LWAIT, S_SQ, S_U, S_HM, S_HA, S_RX, S_S,
    S_SS, S_SSW, S_EX, S_EY, S_ESUM, S_ESQW, S_EDIV, S_EDW, S_NEXTW,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_DONE
  } state_e;

  typedef struct packed {
    logic      in_load;
    logic      phase;
    logic      div_start;
    div_sel_e  div_sel;
    logic      x_load;
    mul_sel_e  mul_sel;
    logic      u_load;
    logic      r_init;
    logic      r_step;
    logic [2:0] hk;
    logic      s_load;
    logic      t_load;
    logic      sqrt_start;
    logic      w_load;
    wsrc_e     wsrc;
    acc_op_e   acc_op;
    logic      mix0_load;
    logic      mix1_load;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    curve_e curve;
    logic   div_busy;
    logic   sqrt_busy;
  } dp_stat_t;

  function automatic logic [Q_W-1:0] hcoef(logic [2:0] k);
    logic [Q_W-1:0] c;
    case (k)
      3'd0:    c = SIN_C9;
      3'd1:    c = SIN_C7;
      3'd2:    c = SIN_C5;
      3'd3:    c = SIN_C3;
      3'd4:    c = SIN_C1;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [WT_W-1:0] q2w(logic [Q_W-1:0] v);
    logic [Q_W:0]    sum;
    logic [WT_W-1:0] w;
    sum = {1'b0, v} + 32'd8192;
    w   = sum[30:14];
    if (w > WT_W'(1 << WEIGHT_W)) begin
      w = WT_W'(1 << WEIGHT_W);
    end
    return w;
  endfunction

endpackage

// ----- rtl/lpcf_in_if.sv -----
// Input channel: four source samples per transfer.
interface lpcf_in_if import lpcf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] before_end_sample;
  logic signed [SAMPLE_W-1:0] before_start_sample;
  logic signed [SAMPLE_W-1:0] after_end_sample;
  logic signed [SAMPLE_W-1:0] from_start_sample;

  modport source (output valid, before_end_sample, before_start_sample,
                  after_end_sample, from_start_sample, input ready);
  modport sink   (input valid, before_end_sample, before_start_sample,
                  after_end_sample, from_start_sample, output ready);
endinterface

// ----- rtl/lpcf_out_if.sv -----
// Output channel: both mixed samples and the last flag per transfer.
interface lpcf_out_if import lpcf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_before_end;
  logic signed [SAMPLE_W-1:0] mixed_after_end;
  logic                       last_sample;

  modport source (output valid, mixed_before_end, mixed_after_end, last_sample,
                  input ready);
  modport sink   (input valid, mixed_before_end, mixed_after_end, last_sample,
                  output ready);
endinterface

// ----- rtl/lpcf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lpcf_div import lpcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [Q_W-1:0]   den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  logic             busy_q;
  logic [5:0]       cnt_q;
  logic [NUM_W-1:0] q_q;
  logic [Q_W-1:0]   rem_q;
  logic [Q_W-1:0]   den_q;
  logic [Q_W:0]     rem_sh;
  logic [Q_W:0]     rem_nx;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, q_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NUM_W-2:0], ge};
      rem_q <= rem_nx[Q_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;

endmodule

// ----- rtl/lpcf_sqrt.sv -----
// Digit-by-digit integer square root, one result bit per cycle.
module lpcf_sqrt import lpcf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ROOT_IN_W-1:0] v_i,
  output logic                 busy_o,
  output logic [Q_W-1:0]       root_o
);

  logic                 busy_q;
  logic [4:0]           cnt_q;
  logic [ROOT_IN_W-1:0] v_q;
  logic [ROOT_IN_W-1:0] res_q;
  logic [ROOT_IN_W-1:0] bit_q;
  logic [ROOT_IN_W:0]   trial;
  logic                 ge;

  always_comb begin
    trial = {1'b0, res_q} + {1'b0, bit_q};
    ge    = {1'b0, v_q} >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      res_q <= '0;
      bit_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 1);
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - trial[ROOT_IN_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[Q_W-1:0];

endmodule

// ----- rtl/lpcf_dp.sv -----
// Datapath: registers, counters, shared multiplier, divider, square root, mixer.
module lpcf_dp import lpcf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  ctrl_cmd_t                  cmd_i,
  output dp_stat_t                   stat_o,
  input  logic signed [SAMPLE_W-1:0] be_i,
  input  logic signed [SAMPLE_W-1:0] bs_i,
  input  logic signed [SAMPLE_W-1:0] ae_i,
  input  logic signed [SAMPLE_W-1:0] fs_i,
  output logic signed [SAMPLE_W-1:0] mixed_before_end_o,
  output logic signed [SAMPLE_W-1:0] mixed_after_end_o,
  output logic                       last_sample_o
);

  function automatic logic [SAMPLE_W-1:0] mag(logic signed [SAMPLE_W-1:0] a);
    return a[SAMPLE_W-1] ? SAMPLE_W'(-a) : SAMPLE_W'(a);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-WEIGHT_W-1:0] sh;
    logic signed [SAMPLE_W-1:0]       r;
    sh = a[ACC_W-1:WEIGHT_W];
    if (sh > (ACC_W-WEIGHT_W)'((1 << (SAMPLE_W - 1)) - 1)) begin
      r = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    end else if (sh < -(ACC_W-WEIGHT_W)'(1 << (SAMPLE_W - 1))) begin
      r = SAMPLE_W'(1 << (SAMPLE_W - 1));
    end else begin
      r = sh[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  logic [FRAME_W-1:0]   fade_len_q;
  curve_e               curve_q;
  logic [CHCNT_W-1:0]   chan_cnt_q;
  logic [FRAME_W-1:0]   fp_q;
  logic [CHAN_W-1:0]    cp_q;

  logic [FRAME_W-1:0]   len;
  logic [FRAME_W-1:0]   den;
  logic [CHCNT_W-1:0]   chans;
  logic [CHCNT_W-1:0]   chans_m1;
  logic                 last_frame;
  logic                 last_chan;
  logic [FRAME_W-1:0]   i_eff;
  logic [FRAME_W-1:0]   n;

  logic signed [SAMPLE_W-1:0] be_q, bs_q, ae_q, fs_q;
  logic [FRAME_W-1:0]   i_q;
  logic                 last_q;
  logic [Q_W-1:0]       x_q, u_q, r_q, s_q;
  logic [ROOT_IN_W-1:0] t_q;
  logic [WT_W-1:0]      w_in_q, w_out_q;
  logic [PROD_W-1:0]    p_q;
  logic                 pneg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [SAMPLE_W-1:0] mix0_q, mix1_q;
  logic signed [SAMPLE_W-1:0] out0_q, out1_q;
  logic                 outl_q;

  logic [NUM_W-1:0]     div_num;
  logic [Q_W-1:0]       div_den;
  logic [NUM_W-1:0]     quo;
  logic                 div_busy;
  logic [Q_W-1:0]       root;
  logic                 sqrt_busy;
  logic [Q_W-1:0]       y;
  logic [31:0]          opa, opb;
  logic                 neg;
  logic [63:0]          prod;
  logic [Q_W-1:0]       s_new;
  logic [PROD_W-1:0]    p_rnd;
  logic [WT_W-1:0]      w_new;
  logic signed [ACC_W-1:0] pext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_len_q <= FRAME_W'(2);
      curve_q    <= CURVE_LINEAR;
      chan_cnt_q <= CHCNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FADE_LENGTH:   fade_len_q <= cfg_wdata_i[FRAME_W-1:0];
        REG_CURVE_TYPE:    curve_q    <= curve_e'(cfg_wdata_i[1:0]);
        REG_CHANNEL_COUNT: chan_cnt_q <= cfg_wdata_i[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len = (fade_len_q < FRAME_W'(2)) ? FRAME_W'(2) : fade_len_q;
    den = len - FRAME_W'(1);
    if (chan_cnt_q == '0) begin
      chans = CHCNT_W'(1);
    end else if (chan_cnt_q > CHCNT_W'(MAX_CHANNELS)) begin
      chans = CHCNT_W'(MAX_CHANNELS);
    end else begin
      chans = chan_cnt_q;
    end
    chans_m1   = chans - CHCNT_W'(1);
    last_frame = fp_q >= den;
    i_eff      = last_frame ? den : fp_q;
    last_chan  = {1'b0, cp_q} >= chans_m1;
    n          = cmd_i.phase ? den - i_q : i_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= '0;
      cp_q <= '0;
    end else if (cmd_i.in_load) begin
      if (last_chan) begin
        cp_q <= '0;
        fp_q <= last_frame ? '0 : fp_q + FRAME_W'(1);
      end else begin
        cp_q <= cp_q + CHAN_W'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_LIN: begin
        div_num = NUM_W'({n, 16'd0}) + NUM_W'(den >> 1);
        div_den = Q_W'(den);
      end
      DIV_EP: begin
        div_num = {x_q, 16'd0} + NUM_W'(root >> 1);
        div_den = root;
      end
      default: begin
        div_num = NUM_W'({n, 30'd0}) + NUM_W'(den >> 1);
        div_den = Q_W'(den);
      end
    endcase
  end

  lpcf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  lpcf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .v_i     (t_q + p_q[ROOT_IN_W-1:0]),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  always_comb begin
    y   = Q30_ONE - x_q;
    opa = '0;
    opb = '0;
    neg = 1'b0;
    unique case (cmd_i.mul_sel)
      MUL_XX: begin opa = 32'(x_q); opb = 32'(x_q); end
      MUL_YY: begin opa = 32'(y);   opb = 32'(y);   end
      MUL_RU: begin opa = 32'(r_q); opb = 32'(u_q); end
      MUL_RX: begin opa = 32'(r_q); opb = 32'(x_q); end
      MUL_SS: begin opa = 32'(s_q); opb = 32'(s_q); end
      MUL_A0: begin opa = 32'(mag(be_q)); opb = 32'(w_out_q); neg = be_q[SAMPLE_W-1]; end
      MUL_A1: begin opa = 32'(mag(bs_q)); opb = 32'(w_in_q);  neg = bs_q[SAMPLE_W-1]; end
      MUL_A2: begin opa = 32'(mag(ae_q)); opb = 32'(w_in_q);  neg = ae_q[SAMPLE_W-1]; end
      MUL_A3: begin opa = 32'(mag(fs_q)); opb = 32'(w_out_q); neg = fs_q[SAMPLE_W-1]; end
      default: ;
    endcase
    prod = opa * opb;

    s_new = (p_q[PROD_W-1:30] > 32'(Q30_ONE)) ? Q30_ONE : p_q[60:30];
    p_rnd = p_q + PROD_W'(1 << 29);

    case (cmd_i.wsrc)
      W_LIN:    w_new = quo[WT_W-1:0];
      W_SINE:   w_new = q2w(s_new);
      W_SCURVE: w_new = q2w(p_rnd[60:30]);
      default:  w_new = (quo > NUM_W'(1 << WEIGHT_W)) ? WT_W'(1 << WEIGHT_W)
                                                       : quo[WT_W-1:0];
    endcase

    pext = ACC_W'(signed'({1'b0, p_q[39:0]}));
  end

  always_ff @(posedge clk_i) begin
    p_q    <= prod[PROD_W-1:0];
    pneg_q <= neg;
    if (cmd_i.in_load) begin
      be_q   <= be_i;
      bs_q   <= bs_i;
      ae_q   <= ae_i;
      fs_q   <= fs_i;
      i_q    <= i_eff;
      last_q <= last_frame && last_chan;
    end
    if (cmd_i.x_load) begin
      x_q <= quo[Q_W-1:0];
    end
    if (cmd_i.u_load) begin
      u_q <= p_q[60:30];
    end
    if (cmd_i.r_init) begin
      r_q <= SIN_C11;
    end else if (cmd_i.r_step) begin
      r_q <= hcoef(cmd_i.hk) - p_q[60:30];
    end
    if (cmd_i.s_load) begin
      s_q <= s_new;
    end
    if (cmd_i.t_load) begin
      t_q <= p_q[ROOT_IN_W-1:0];
    end
    if (cmd_i.w_load) begin
      if (cmd_i.phase) begin
        w_out_q <= w_new;
      end else begin
        w_in_q <= w_new;
      end
    end
    case (cmd_i.acc_op)
      ACC_CLR: acc_q <= ACC_W'(1 << (WEIGHT_W - 1));
      ACC_ADD: acc_q <= pneg_q ? acc_q - pext : acc_q + pext;
      default: ;
    endcase
    if (cmd_i.mix0_load) begin
      mix0_q <= sat(acc_q);
    end
    if (cmd_i.mix1_load) begin
      mix1_q <= sat(acc_q);
    end
    if (cmd_i.out_load) begin
      out0_q <= mix0_q;
      out1_q <= mix1_q;
      outl_q <= last_q;
    end
  end

  assign stat_o.curve     = curve_q;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.sqrt_busy = sqrt_busy;

  assign mixed_before_end_o = out0_q;
  assign mixed_after_end_o  = out1_q;
  assign last_sample_o      = outl_q;

endmodule

// ----- rtl/lpcf_ctrl.sv -----
// Controller: sequences weight evaluation, mixing and the output transfer.
module lpcf_ctrl import lpcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic       phase_q, phase_d;
  logic [2:0] k_q, k_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    cmd_o.hk    = k_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          phase_d       = 1'b0;
          state_d       = S_XDIV;
        end
      end
      S_XDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_X;
        state_d         = S_XWAIT;
      end
      S_XWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.x_load = 1'b1;
          unique case (stat_i.curve)
            CURVE_LINEAR: state_d = S_LDIV;
            CURVE_EQPOW:  state_d = S_EX;
            default:      state_d = S_SQ;
          endcase
        end
      end
      S_LDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_LIN;
        state_d         = S_LWAIT;
      end
      S_LWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.w_load = 1'b1;
          cmd_o.wsrc   = W_LIN;
          state_d      = S_NEXTW;
        end
      end
      S_SQ: begin
        cmd_o.mul_sel = MUL_XX;
        state_d       = S_U;
      end
      S_U: begin
        cmd_o.u_load = 1'b1;
        cmd_o.r_init = 1'b1;
        k_d          = '0;
        state_d      = S_HM;
      end
      S_HM: begin
        cmd_o.mul_sel = MUL_RU;
        state_d       = S_HA;
      end
      S_HA: begin
        cmd_o.r_step = 1'b1;
        k_d          = k_q + 3'd1;
        state_d      = (k_q == HORNER_LAST) ? S_RX : S_HM;
      end
      S_RX: begin
        cmd_o.mul_sel = MUL_RX;
        state_d       = S_S;
      end
      S_S: begin
        cmd_o.s_load = 1'b1;
        if (stat_i.curve == CURVE_SINE) begin
          cmd_o.w_load = 1'b1;
          cmd_o.wsrc   = W_SINE;
          state_d      = S_NEXTW;
        end else begin
          state_d = S_SS;
        end
      end
      S_SS: begin
        cmd_o.mul_sel = MUL_SS;
        state_d       = S_SSW;
      end
      S_SSW: begin
        cmd_o.w_load = 1'b1;
        cmd_o.wsrc   = W_SCURVE;
        state_d      = S_NEXTW;
      end
      S_EX: begin
        cmd_o.mul_sel = MUL_XX;
        state_d       = S_EY;
      end
      S_EY: begin
        cmd_o.t_load  = 1'b1;
        cmd_o.mul_sel = MUL_YY;
        state_d       = S_ESUM;
      end
      S_ESUM: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_ESQW;
      end
      S_ESQW: begin
        if (!stat_i.sqrt_busy) begin
          state_d = S_EDIV;
        end
      end
      S_EDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_EP;
        state_d         = S_EDW;
      end
      S_EDW: begin
        cmd_o.div_sel = DIV_EP;
        if (!stat_i.div_busy) begin
          cmd_o.w_load = 1'b1;
          cmd_o.wsrc   = W_EP;
          state_d      = S_NEXTW;
        end
      end
      S_NEXTW: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_XDIV;
        end else begin
          state_d = S_M0;
        end
      end
      S_M0: begin
        cmd_o.acc_op  = ACC_CLR;
        cmd_o.mul_sel = MUL_A0;
        state_d       = S_M1;
      end
      S_M1: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_sel = MUL_A1;
        state_d       = S_M2;
      end
      S_M2: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_M3;
      end
      S_M3: begin
        cmd_o.mix0_load = 1'b1;
        cmd_o.acc_op    = ACC_CLR;
        cmd_o.mul_sel   = MUL_A2;
        state_d         = S_M4;
      end
      S_M4: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_sel = MUL_A3;
        state_d       = S_M5;
      end
      S_M5: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_M6;
      end
      S_M6: begin
        cmd_o.mix1_load = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/loop_point_crossfader_core.sv -----
// Loop point crossfader top level: controller, datapath and channel hookup.
// One item at a time: the next input transfer waits until the last item is through the
// divider (twice per weight for linear and equal power), the square root (equal power
// only) and the mixing steps, for two weights per item; the result turns valid as the
// core returns to accept input. Output stalls can hold the core before it returns.
// Reset (rst_ni low, async) clears counters, sets defaults.
module loop_point_crossfader_core import lpcf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lpcf_in_if.sink               in_ch,
  lpcf_out_if.source            out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lpcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpcf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .be_i               (in_ch.before_end_sample),
    .bs_i               (in_ch.before_start_sample),
    .ae_i               (in_ch.after_end_sample),
    .fs_i               (in_ch.from_start_sample),
    .mixed_before_end_o (out_ch.mixed_before_end),
    .mixed_after_end_o  (out_ch.mixed_after_end),
    .last_sample_o      (out_ch.last_sample)
  );

endmodule

// ----- tb/loop_point_crossfader_core_test.sv -----
// Self-checking testbench of the loop point crossfader core, with its own fixed-point predictor.
`timescale 1ns / 1ps
module loop_point_crossfader_core_test;
  import lpcf_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 4_000_000;
  localparam int              SETTLE_CYCLES = 400;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mixed_before_end;
    logic signed [SAMPLE_W-1:0] mixed_after_end;
    logic                       last_sample;
  } mix_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lpcf_in_if  in_ch ();
  lpcf_out_if out_ch ();

  loop_point_crossfader_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source)
  );

  mix_result_t     pending_mixes[$];
  int unsigned     error_count;
  longint unsigned cycle_count;

  logic [FRAME_W-1:0] fade_len_q;
  curve_e             curve_q;
  logic [CHCNT_W-1:0] chan_cnt_q;
  logic [FRAME_W-1:0] frame_pos_q;
  logic [CHAN_W-1:0]  chan_pos_q;

  int unsigned burst_left;
  logic        hold_trig;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned u;
    longint unsigned r;
    u = (x * x) >> 30;
    r = SIN_C11;
    r = SIN_C9 - ((r * u) >> 30);
    r = SIN_C7 - ((r * u) >> 30);
    r = SIN_C5 - ((r * u) >> 30);
    r = SIN_C3 - ((r * u) >> 30);
    r = SIN_C1 - ((r * u) >> 30);
    r = (r * x) >> 30;
    return (r > Q30_ONE) ? Q30_ONE : r;
  endfunction

  function automatic longint unsigned phase_to_weight(longint unsigned v);
    longint unsigned w;
    w = (v + (64'd1 << 13)) >> 14;
    return (w > (64'd1 << WEIGHT_W)) ? (64'd1 << WEIGHT_W) : w;
  endfunction

  function automatic longint unsigned fade_weight(longint unsigned i, longint unsigned len,
                                                  curve_e curve);
    longint unsigned den;
    longint unsigned x;
    longint unsigned y;
    longint unsigned s;
    longint unsigned d;
    longint unsigned w;
    den = len - 1;
    x   = ((i << 30) + den / 2) / den;
    case (curve)
      CURVE_LINEAR: w = ((i << WEIGHT_W) + den / 2) / den;
      CURVE_SCURVE: begin
        s = quarter_sine(x);
        w = phase_to_weight((s * s + (64'd1 << 29)) >> 30);
      end
      CURVE_EQPOW: begin
        y = Q30_ONE - x;
        d = root_floor(x * x + y * y);
        if (d == 0) begin
          w = 0;
        end else begin
          w = ((x << WEIGHT_W) + d / 2) / d;
          if (w > (64'd1 << WEIGHT_W)) w = 64'd1 << WEIGHT_W;
        end
      end
      default: w = phase_to_weight(quarter_sine(x));
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] weighted_sum(
      logic signed [SAMPLE_W-1:0] a, longint unsigned wa,
      logic signed [SAMPLE_W-1:0] b, longint unsigned wb);
    longint v;
    longint r;
    v = longint'(a) * longint'(wa) + longint'(b) * longint'(wb) + (64'sd1 <<< (WEIGHT_W - 1));
    r = v >>> WEIGHT_W;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic predict_mix(logic signed [SAMPLE_W-1:0] be, logic signed [SAMPLE_W-1:0] bs,
                             logic signed [SAMPLE_W-1:0] ae, logic signed [SAMPLE_W-1:0] fs);
    longint unsigned len;
    longint unsigned chans;
    longint unsigned i;
    longint unsigned w_in;
    longint unsigned w_out;
    logic            last_frame;
    logic            last_chan;
    mix_result_t     res;
    len   = (fade_len_q < 2) ? 2 : fade_len_q;
    chans = (chan_cnt_q == 0) ? 1 : ((chan_cnt_q > MAX_CHANNELS) ? MAX_CHANNELS : chan_cnt_q);
    i     = frame_pos_q;
    last_frame = (i >= len - 1);
    if (last_frame) i = len - 1;
    last_chan = (chan_pos_q >= chans - 1);
    w_in  = fade_weight(i, len, curve_q);
    w_out = fade_weight(len - 1 - i, len, curve_q);
    res.mixed_before_end = weighted_sum(be, w_out, bs, w_in);
    res.mixed_after_end  = weighted_sum(ae, w_in, fs, w_out);
    res.last_sample      = last_frame && last_chan;
    pending_mixes = {pending_mixes, res};
    if (last_chan) begin
      chan_pos_q  = '0;
      frame_pos_q = last_frame ? '0 : frame_pos_q + 1'b1;
    end else begin
      chan_pos_q = chan_pos_q + 1'b1;
    end
  endtask

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_samples(logic signed [SAMPLE_W-1:0] be, logic signed [SAMPLE_W-1:0] bs,
                              logic signed [SAMPLE_W-1:0] ae, logic signed [SAMPLE_W-1:0] fs);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    in_ch.valid               <= 1'b1;
    in_ch.before_end_sample   <= be;
    in_ch.before_start_sample <= bs;
    in_ch.after_end_sample    <= ae;
    in_ch.from_start_sample   <= fs;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_mix(be, bs, ae, fs);
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_mixes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_FADE_LENGTH:   fade_len_q = value;
      REG_CURVE_TYPE:    curve_q    = curve_e'(value[1:0]);
      REG_CHANNEL_COUNT: chan_cnt_q = value[CHCNT_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_fade(logic [15:0] len, curve_e curve, logic [15:0] chans);
    drain_block();
    cfg_write(REG_FADE_LENGTH, len);
    cfg_write(REG_CURVE_TYPE, CFG_DATA_W'(curve));
    cfg_write(REG_CHANNEL_COUNT, chans);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return SAMPLE_W'($urandom_range(0, 15)) - 24'sd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    repeat (n) send_samples(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endtask

  task automatic test_reset_defaults();
    send_samples(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_samples(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000);
    send_samples(24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF);
    send_samples(24'sh000001, 24'shFFFFFF, 24'sh555555, 24'shAAAAAA);
  endtask

  task automatic test_each_curve();
    curve_e c;
    for (int k = 0; k < 4; k++) begin
      c = curve_e'(k);
      set_fade(16'd3, c, 16'd1);
      send_samples(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
      send_samples(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000);
      send_samples(24'sh123456, 24'shEDCBA9, 24'sh800000, 24'sh7FFFFF);
    end
  endtask

  task automatic test_counter_past_end();
    set_fade(16'd200, CURVE_EQPOW, 16'd3);
    send_random(8);
    drain_block();
    cfg_write(REG_FADE_LENGTH, 16'd2);
    cfg_write(REG_CHANNEL_COUNT, 16'd1);
    send_random(3);
  endtask

  task automatic test_register_extremes();
    set_fade(16'd0, CURVE_SINE, 16'd0);
    send_random(2);
    set_fade(16'd1, CURVE_SCURVE, 16'd15);
    send_random(3);
    set_fade(16'hFFFF, CURVE_LINEAR, 16'hFFF8);
    send_random(3);
  endtask

  // Stall the output long enough that the core backs up into its input.
  task automatic test_output_backpressure();
    set_fade(16'd5, CURVE_SINE, 16'd2);
    hold_trig <= ~hold_trig;
    burst_left = 30;
    send_random(25);
  endtask

  task automatic test_random_fades();
    logic [15:0] len;
    logic [15:0] chans;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 4))
        0: len = 16'd2;
        1: len = 16'hFFFF;
        2: len = 16'($urandom);
        default: len = 16'($urandom_range(0, 40));
      endcase
      chans = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
      set_fade(len, curve_e'($urandom_range(0, 3)), chans);
      send_random(130);
    end
  endtask

  int unsigned hold_left;
  int unsigned mode_left;
  int unsigned ready_pct;
  logic        hold_seen;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= hold_trig;
      mode_left    <= 0;
      ready_pct    <= 100;
    end else begin
      if (hold_seen != hold_trig) begin
        hold_seen <= hold_trig;
        hold_left <= 3000;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left <= $urandom_range(50, 600);
          case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 90;
            2: ready_pct <= 50;
            default: ready_pct <= 10;
          endcase
        end else begin
          mode_left <= mode_left - 1;
        end
        out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    mix_result_t exp_mix;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_mixes.size() == 0) begin
        $display("%0t: unexpected transfer mbe=%0d mae=%0d last=%0b", $time,
                 out_ch.mixed_before_end, out_ch.mixed_after_end, out_ch.last_sample);
        error_count = error_count + 1;
      end else begin
        exp_mix = pending_mixes.pop_front();
        if (out_ch.mixed_before_end !== exp_mix.mixed_before_end) begin
          $display("%0t: mixed_before_end expected %0d actual %0d", $time,
                   exp_mix.mixed_before_end, out_ch.mixed_before_end);
          error_count = error_count + 1;
        end
        if (out_ch.mixed_after_end !== exp_mix.mixed_after_end) begin
          $display("%0t: mixed_after_end expected %0d actual %0d", $time,
                   exp_mix.mixed_after_end, out_ch.mixed_after_end);
          error_count = error_count + 1;
        end
        if (out_ch.last_sample !== exp_mix.last_sample) begin
          $display("%0t: last_sample expected %0b actual %0b", $time,
                   exp_mix.last_sample, out_ch.last_sample);
          error_count = error_count + 1;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    burst_left  = 0;
    hold_trig   = 1'b0;
    fade_len_q  = 16'd2;
    curve_q     = CURVE_LINEAR;
    chan_cnt_q  = 4'd1;
    frame_pos_q = '0;
    chan_pos_q  = '0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.before_end_sample   = '0;
    in_ch.before_start_sample = '0;
    in_ch.after_end_sample    = '0;
    in_ch.from_start_sample   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_each_curve();
    test_counter_past_end();
    test_register_extremes();
    test_output_backpressure();
    test_random_fades();
    drain_block();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
